@@ hw/rtl/sps_pkg.sv @@
// Shared types and constants for the signature pattern scanner.
package sps_pkg;

	localparam int PATTERN_MAX = 256;
	localparam int CHUNK_MAX_BYTES = 8;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_SCAN = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] REG_CHUNK_BYTES = 2'd1;
	localparam logic [1:0] REG_MAX_DISTANCE = 2'd2;

	localparam logic [8:0] PATTERN_LENGTH_RST = 9'd1;
	localparam logic [3:0] CHUNK_BYTES_RST = 4'd0;
	localparam logic [15:0] MAX_DISTANCE_RST = 16'd3000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] pattern_index;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic found;
		logic [31:0] match_offset;
	} result_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic scan;
		logic clear;
	} cell_ctl_t;

endpackage

@@ hw/rtl/sps_cell.sv @@
// One scan cell: holds one recent byte and one pattern byte.
module sps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sps_pkg::cell_ctl_t  ctl,
	input  logic                pat_we,
	input  logic [7:0]          pat_wdata,
	input  logic [7:0]          shift_in,
	output logic [7:0]          shift_out,
	input  logic [7:0]          pat_cmp,
	output logic [7:0]          pat_byte,
	output logic                eq_next
);

	logic [7:0] data_q;
	logic [7:0] pat_q;

	// Recent-byte shift stage, cleared on finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
		end else if (ctl.scan) begin
			data_q <= shift_in;
		end
	end

	// Pattern byte.
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_q <= pat_wdata;
		end
	end

	assign shift_out = data_q;
	assign pat_byte = pat_q;
	// Compare of the byte this cell will hold after a scan against a pattern byte.
	assign eq_next = (shift_in == pat_cmp);

endmodule

@@ hw/rtl/signature_pattern_scanner_top.sv @@
// Top level of the signature pattern scanner.
// Load, scan and unused commands are taken while busy is low and leave busy low,
// so they may be issued every cycle while busy is low. A finish holds busy high while
// the sequencer walks the chunks (at most PatternMax, fewer when a chunk fails, none in
// exact mode, with too few bytes or with no chunks) and then reports; result_valid pulses
// for one cycle as busy falls. The receiver cannot stall the result.
module signature_pattern_scanner_top #(
	parameter int PatternMax = sps_pkg::PATTERN_MAX,
	parameter int ChunkMaxBytes = sps_pkg::CHUNK_MAX_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sps_pkg::item_t     item,
	output logic               result_valid,
	output sps_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LW = $clog2(PatternMax + 1);
	localparam int CW = $clog2(ChunkMaxBytes + 1);
	localparam int SH = LW + 4;
	localparam int RW = SH + 1;
	localparam int PW = LW + RW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [8:0] pattern_length_q;
	logic [3:0] chunk_bytes_q;
	logic [15:0] max_distance_q;

	logic [1:0] state_q;
	logic accept;
	sps_pkg::cell_ctl_t ctl;

	logic [7:0] chain [PatternMax+1];
	logic [7:0] pbyte [PatternMax];
	logic [PatternMax-1:0] eq_exact;
	logic [7:0] cmp_sel [PatternMax];

	logic [31:0] bytes_q;
	logic [31:0] end_next;
	logic exact_hit_q;
	logic [31:0] exact_off_q;
	logic [PatternMax-1:0] seen_q;
	logic [31:0] coff_q [PatternMax];

	logic [LW-1:0] len_eff;
	logic [CW-1:0] cb_eff;
	logic [LW-1:0] n_chunks;
	logic [LW-1:0] quot [ChunkMaxBytes+1];

	logic [LW-1:0] walk_q;
	logic [31:0] min_q;
	logic ok_q;
	logic [31:0] limit_q;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign ctl.scan = accept && (item.cmd == sps_pkg::CMD_SCAN);
	assign ctl.clear = (state_q == ST_DONE);

	// Effective lengths, clamped to the store sizes.
	always_comb begin
		if (32'(pattern_length_q) > 32'(PatternMax)) len_eff = LW'(PatternMax);
		else len_eff = LW'(pattern_length_q);
		if (32'(chunk_bytes_q) > 32'(ChunkMaxBytes)) cb_eff = CW'(ChunkMaxBytes);
		else cb_eff = CW'(chunk_bytes_q);
	end

	// Chunk count: reciprocal multiply per chunk size, exact for every length.
	assign quot[0] = '0;
	for (genvar k = 1; k <= ChunkMaxBytes; k++) begin : g_quot
		localparam logic [RW-1:0] RECIP = RW'(((1 << SH) + k - 1) / k);
		logic [PW-1:0] prod;
		assign prod = PW'(len_eff) * PW'(RECIP);
		assign quot[k] = prod[SH+LW-1:SH];
	end
	assign n_chunks = quot[cb_eff];

	assign chain[0] = item.byte_value;

	// Row of cells. Cell i holds recent byte i.
	for (genvar i = 0; i < PatternMax; i++) begin : g_cell
		// Exact compare: recent byte i after shift vs pattern[len-1-i].
		always_comb begin
			cmp_sel[i] = 8'h00;
			for (int j = 0; j < PatternMax; j++) begin
				if (32'(len_eff) == j + i + 1) cmp_sel[i] = pbyte[j];
			end
		end
		sps_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.pat_we(accept && item.cmd == sps_pkg::CMD_LOAD &&
				32'(item.pattern_index) == i),
			.pat_wdata(item.byte_value),
			.shift_in(chain[i]), .shift_out(chain[i+1]),
			.pat_cmp(cmp_sel[i]), .pat_byte(pbyte[i]),
			.eq_next(eq_exact[i])
		);
	end

	// Exact match of the newest len bytes.
	logic exact_eq;
	always_comb begin
		exact_eq = 1'b1;
		for (int i = 0; i < PatternMax; i++) begin
			if (i < 32'(len_eff) && !eq_exact[i]) exact_eq = 1'b0;
		end
	end

	// Chunk compare: chunk c matches if pattern[c*cb+j] == recent[cb-1-j].
	logic [PatternMax-1:0] chunk_eq;
	always_comb begin
		for (int c = 0; c < PatternMax; c++) begin
			chunk_eq[c] = 1'b0;
			for (int k = 1; k <= ChunkMaxBytes; k++) begin
				if (32'(cb_eff) == k && c * k + k <= PatternMax) begin
					chunk_eq[c] = 1'b1;
					for (int j = 0; j < k; j++) begin
						if (((c * k + j) < PatternMax) && (chain[k-1-j] !=
						    pbyte[((c * k + j) < PatternMax) ? (c * k + j) : 0]))
							chunk_eq[c] = 1'b0;
					end
				end
			end
		end
	end

	assign end_next = (bytes_q == 32'hFFFF_FFFF) ? bytes_q : bytes_q + 32'd1;

	// Scan state: count, exact hit, chunk flags (shifted toward 0 during the walk).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			exact_hit_q <= 1'b0;
			exact_off_q <= '0;
			seen_q <= '0;
		end else if (ctl.clear) begin
			bytes_q <= '0;
			exact_hit_q <= 1'b0;
			exact_off_q <= '0;
			seen_q <= '0;
		end else if (ctl.scan) begin
			bytes_q <= end_next;
			if (cb_eff == '0) begin
				if (len_eff != '0 && end_next >= 32'(len_eff) && !exact_hit_q && exact_eq) begin
					exact_hit_q <= 1'b1;
					exact_off_q <= end_next - 32'(len_eff);
				end
			end else if (end_next >= 32'(cb_eff)) begin
				for (int c = 0; c < PatternMax; c++) begin
					if (c < 32'(n_chunks) && !seen_q[c] && chunk_eq[c]) seen_q[c] <= 1'b1;
				end
			end
		end else if (state_q == ST_WALK) begin
			seen_q <= seen_q >> 1;
		end
	end

	// Chunk offsets; unseen entries are never read as valid. Shifted during the walk.
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK) begin
			for (int c = 0; c < PatternMax - 1; c++) coff_q[c] <= coff_q[c+1];
		end else if (ctl.scan && cb_eff != '0 && end_next >= 32'(cb_eff)) begin
			for (int c = 0; c < PatternMax; c++) begin
				if (c < 32'(n_chunks) && !seen_q[c] && chunk_eq[c])
					coff_q[c] <= end_next - 32'(cb_eff);
			end
		end
	end

	// Finish sequencer: walk chunks one per cycle, always reading entry 0.
	logic [31:0] woff;
	logic [31:0] wmin;
	assign woff = coff_q[0];
	assign wmin = (woff < min_q) ? woff : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q <= '0;
			min_q <= '0;
			ok_q <= 1'b0;
			limit_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == sps_pkg::CMD_FINISH) begin
						walk_q <= '0;
						limit_q <= bytes_q - 32'(len_eff);
						if (bytes_q < 32'(len_eff)) begin
							ok_q <= 1'b0;
							min_q <= 32'hFFFF_FFFF;
							state_q <= ST_DONE;
						end else if (cb_eff == '0) begin
							ok_q <= (len_eff == '0) || exact_hit_q;
							min_q <= (len_eff == '0) ? 32'd0 : exact_off_q;
							state_q <= ST_DONE;
						end else begin
							ok_q <= (n_chunks != '0);
							min_q <= 32'hFFFF_FFFF;
							state_q <= (n_chunks != '0) ? ST_WALK : ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (!seen_q[0] || woff > limit_q ||
					    (woff - wmin) > 32'(max_distance_q)) begin
						ok_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						min_q <= wmin;
						walk_q <= walk_q + 1'b1;
						if (walk_q + 1'b1 == n_chunks) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					result.found <= ok_q;
					result.match_offset <= ok_q ? min_q : 32'd0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= sps_pkg::PATTERN_LENGTH_RST;
			chunk_bytes_q <= sps_pkg::CHUNK_BYTES_RST;
			max_distance_q <= sps_pkg::MAX_DISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[8:0];
				sps_pkg::REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[3:0];
				sps_pkg::REG_MAX_DISTANCE: max_distance_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> result_valid) else $error("missing result");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == ST_DONE) else $error("stray result");
	a_busy_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == sps_pkg::CMD_FINISH) |=> busy) else $error("finish not busy");
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> result.match_offset == 32'd0) else $error("offset");
`endif

endmodule
